@@ src/spq_pkg.sv @@
// Shared constants, types and codes for the stable priority ready queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PRIO_BITS   = 8;

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + PRIO_BITS;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        kind_t                kind;
        logic [ID_BITS-1:0]   task_id;
        logic [PRIO_BITS-1:0] task_priority;
    } item_t;

    typedef struct packed {
        logic [ID_BITS-1:0] popped_id;
        logic               popped_valid;
        status_t            status;
        logic [ID_BITS-1:0] head_id;
        logic               is_empty;
        cnt_t               entry_count;
    } result_t;

endpackage

@@ src/stable_priority_ready_queue.sv @@
// Top level of the stable priority ready queue: handshakes and result register.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_kind, s_task_id, s_task_priority
//   m_       out        m_valid / m_ready  m_popped_id, m_popped_valid, m_status,
//                                          m_head_id, m_is_empty, m_entry_count
//
// A word is accepted in ST_IDLE, walks the entry RAM one entry at a time in ST_WALK
// (one read and one write a cycle against a single priority compare), places a push
// at the head in ST_PLACE when needed, and hands the result over from ST_DONE.
// Refused words, pops of the last entry and pushes into an empty queue skip ST_WALK.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
// s_ready is low while a word is in work; a stalled m_ channel holds the engine
// only once its result is done, and the result register frees as it is taken.
module stable_priority_ready_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [spq_pkg::ID_BITS-1:0]     s_task_id,
    input  logic [spq_pkg::PRIO_BITS-1:0]   s_task_priority,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [spq_pkg::ID_BITS-1:0]     m_popped_id,
    output logic                            m_popped_valid,
    output logic [1:0]                      m_status,
    output logic [spq_pkg::ID_BITS-1:0]     m_head_id,
    output logic                            m_is_empty,
    output logic [spq_pkg::CNT_W-1:0]       m_entry_count
);
    import spq_pkg::*;

    logic    eng_idle;
    logic    eng_done;
    logic    res_ready;
    logic    start;
    item_t   item;
    result_t res;
    logic    load;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    assign s_ready = eng_idle;
    assign start   = s_valid && eng_idle;

    always_comb begin
        item.kind          = kind_t'(s_kind);
        item.task_id       = s_task_id;
        item.task_priority = s_task_priority;
    end

    spq_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item      (item),
        .idle      (eng_idle),
        .done      (eng_done),
        .res_ready (res_ready),
        .res       (res)
    );

    // output slot is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;
    assign load      = eng_done && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_id    = m_res_reg.popped_id;
    assign m_popped_valid = m_res_reg.popped_valid;
    assign m_status       = m_res_reg.status;
    assign m_head_id      = m_res_reg.head_id;
    assign m_is_empty     = m_res_reg.is_empty;
    assign m_entry_count  = m_res_reg.entry_count;

endmodule

@@ src/spq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/spq_engine.sv @@
// Sequencer that walks the sorted entry RAM one slot a cycle to push or pop a word.
module spq_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  spq_pkg::item_t   item,
    output logic             idle,
    output logic             done,
    input  logic             res_ready,
    output spq_pkg::result_t res
);
    import spq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_PLACE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam cnt_t DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    state_t               state_reg, state_next;
    cnt_t                 count_reg, count_next;
    idx_t                 rd_idx_reg, rd_idx_next;
    kind_t                op_kind_reg, op_kind_next;
    logic [ID_BITS-1:0]   new_id_reg, new_id_next;
    logic [PRIO_BITS-1:0] new_prio_reg, new_prio_next;
    logic [ID_BITS-1:0]   head_reg, head_next;
    logic [ID_BITS-1:0]   popped_id_reg, popped_id_next;
    logic                 popped_valid_reg, popped_valid_next;
    status_t              status_reg, status_next;

    logic   ram_wr_en;
    idx_t   ram_wr_addr;
    entry_t ram_wr_data;
    logic   ram_rd_en;
    idx_t   ram_rd_addr;
    entry_t ram_rd_data;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        op_kind_next      = op_kind_reg;
        new_id_next       = new_id_reg;
        new_prio_next     = new_prio_reg;
        head_next         = head_reg;
        popped_id_next    = popped_id_reg;
        popped_valid_next = popped_valid_reg;
        status_next       = status_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = rd_idx_reg;
        ram_wr_data       = '{id: new_id_reg, prio: new_prio_reg};
        ram_rd_en         = 1'b0;
        ram_rd_addr       = rd_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_kind_next      = item.kind;
                    new_id_next       = item.task_id;
                    new_prio_next     = item.task_priority;
                    popped_id_next    = '0;
                    popped_valid_next = 1'b0;
                    status_next       = STATUS_OK;
                    if (item.kind == KIND_PUSH) begin
                        if (count_reg == DEPTH_CNT) begin
                            status_next = STATUS_FULL;
                            state_next  = ST_DONE;
                        end else if (count_reg == '0) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = '0;
                            ram_wr_data = '{id: item.task_id, prio: item.task_priority};
                            head_next   = item.task_id;
                            count_next  = count_reg + 1'b1;
                            state_next  = ST_DONE;
                        end else begin
                            // start at the tail and move toward the head
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = IDX_W'(count_reg - 1'b1);
                            rd_idx_next = IDX_W'(count_reg - 1'b1);
                            state_next  = ST_WALK;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else begin
                            popped_id_next    = head_reg;
                            popped_valid_next = 1'b1;
                            if (count_reg == CNT_W'(1)) begin
                                count_next = '0;
                                state_next = ST_DONE;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = IDX_W'(1);
                                rd_idx_next = IDX_W'(1);
                                state_next  = ST_WALK;
                            end
                        end
                    end
                end
            end
            ST_WALK: begin
                ram_wr_en = 1'b1;
                if (op_kind_reg == KIND_PUSH) begin
                    ram_wr_addr = rd_idx_reg + 1'b1;
                    if (ram_rd_data.prio < new_prio_reg) begin
                        // lower priority entry: shift it back one slot
                        ram_wr_data = ram_rd_data;
                        if (rd_idx_reg == '0) begin
                            state_next = ST_PLACE;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = rd_idx_reg - 1'b1;
                            rd_idx_next = rd_idx_reg - 1'b1;
                        end
                    end else begin
                        // equal or higher priority ahead: drop the new word behind it
                        count_next = count_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                end else begin
                    ram_wr_addr = rd_idx_reg - 1'b1;
                    ram_wr_data = ram_rd_data;
                    if (rd_idx_reg == IDX_W'(1)) begin
                        head_next = ram_rd_data.id;
                    end
                    if (CNT_W'(rd_idx_reg) + CNT_W'(1) == count_reg) begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_idx_reg + 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            ST_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                head_next   = new_id_reg;
                count_next  = count_reg + 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        rd_idx_reg       <= rd_idx_next;
        op_kind_reg      <= op_kind_next;
        new_id_reg       <= new_id_next;
        new_prio_reg     <= new_prio_next;
        head_reg         <= head_next;
        popped_id_reg    <= popped_id_next;
        popped_valid_reg <= popped_valid_next;
        status_reg       <= status_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb begin
        res.popped_id    = popped_id_reg;
        res.popped_valid = popped_valid_reg;
        res.status       = status_reg;
        res.head_id      = (count_reg == '0) ? '0 : head_reg;
        res.is_empty     = (count_reg == '0);
        res.entry_count  = count_reg;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond queue depth");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == ST_IDLE)
        else $error("word started while engine busy");

    a_done_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_ready) |=> state_reg == ST_IDLE)
        else $error("engine did not release after result handoff");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && status_reg == STATUS_FULL)
            |-> (op_kind_reg == KIND_PUSH && count_reg == DEPTH_CNT))
        else $error("full status without full queue on push");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && popped_valid_reg)
            |-> (op_kind_reg == KIND_POP && status_reg == STATUS_OK))
        else $error("popped word flagged on failed or push operation");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the stable priority ready queue: random push/pop words, both sides stalled.
module tb_top;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_WORDS = 1100;

    // Mirror of the queue contents; predicts the result word of each accepted word.
    class priority_queue_mirror;
        entry_t  slots [QUEUE_DEPTH];
        int      occupancy;
        result_t pending_results [$];
        int      mismatches;

        function new();
            occupancy  = 0;
            mismatches = 0;
        endfunction

        function void note_word(kind_t kind, logic [ID_BITS-1:0] id,
                                logic [PRIO_BITS-1:0] prio);
            result_t r;
            int pos;
            r = '0;
            r.status = STATUS_OK;
            if (kind == KIND_PUSH) begin
                if (occupancy >= QUEUE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    // go behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < occupancy && prio <= slots[pos].prio)
                        pos++;
                    for (int i = occupancy; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos].id   = id;
                    slots[pos].prio = prio;
                    occupancy++;
                end
            end else begin
                if (occupancy == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.popped_id    = slots[0].id;
                    r.popped_valid = 1'b1;
                    for (int i = 1; i < occupancy; i++)
                        slots[i-1] = slots[i];
                    occupancy--;
                end
            end
            r.head_id     = (occupancy > 0) ? slots[0].id : '0;
            r.is_empty    = (occupancy == 0);
            r.entry_count = cnt_t'(occupancy);
            pending_results.push_back(r);
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit bad;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            bad = 1'b0;
            bad |= field_differs("popped_id", 32'(want.popped_id), 32'(got.popped_id));
            bad |= field_differs("popped_valid", 32'(want.popped_valid),
                                 32'(got.popped_valid));
            bad |= field_differs("status", 32'(want.status), 32'(got.status));
            bad |= field_differs("head_id", 32'(want.head_id), 32'(got.head_id));
            bad |= field_differs("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            bad |= field_differs("entry_count", 32'(want.entry_count),
                                 32'(got.entry_count));
            if (bad)
                mismatches++;
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic [ID_BITS-1:0]   s_task_id;
    logic [PRIO_BITS-1:0] s_task_priority;
    logic                 m_valid;
    logic                 m_ready;
    logic [ID_BITS-1:0]   m_popped_id;
    logic                 m_popped_valid;
    logic [1:0]           m_status;
    logic [ID_BITS-1:0]   m_head_id;
    logic                 m_is_empty;
    logic [CNT_W-1:0]     m_entry_count;

    priority_queue_mirror sb = new();
    int idle_mode = 1;    // 0: no gaps, 1: short gaps, 2: short and long gaps
    int cycles = 0;

    stable_priority_ready_queue i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_task_id       (s_task_id),
        .s_task_priority (s_task_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_popped_id     (m_popped_id),
        .m_popped_valid  (m_popped_valid),
        .m_status        (m_status),
        .m_head_id       (m_head_id),
        .m_is_empty      (m_is_empty),
        .m_entry_count   (m_entry_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[stable_priority_ready_queue] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_popped_id, m_popped_valid, status_t'(m_status),
                             m_head_id, m_is_empty, cnt_t'(m_entry_count)});
    end

    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92 || mode == 1)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: alternate ready runs and stalls.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
            stall = pick_gap(idle_mode);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(kind_t kind, logic [ID_BITS-1:0] id,
                             logic [PRIO_BITS-1:0] prio);
        int gap;
        gap = pick_gap(idle_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_task_id       <= id;
        s_task_priority <= prio;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(kind, id, prio);
        @(negedge aclk);
    endtask

    function automatic logic [PRIO_BITS-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return PRIO_BITS'($urandom_range(0, 3));          // crowd ties
        if (r < 50)
            return $urandom_range(0, 1) ? '1 : '0;
        return PRIO_BITS'($urandom_range(0, 255));
    endfunction

    initial begin
        int burst_left;
        int push_pct;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = KIND_PUSH;
        s_task_id       = '0;
        s_task_priority = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // pop from empty, extremes, equal-priority order, fill, push when full, three pops
        send_word(KIND_POP, 8'hFF, 8'hFF);
        send_word(KIND_PUSH, 8'hFF, 8'h00);
        send_word(KIND_PUSH, 8'h00, 8'hFF);
        send_word(KIND_PUSH, 8'h01, 8'h80);
        send_word(KIND_PUSH, 8'h02, 8'h80);
        send_word(KIND_PUSH, 8'h03, 8'h80);
        for (int i = 0; i < 11; i++)
            send_word(KIND_PUSH, ID_BITS'(8'h10 + i), PRIO_BITS'((i % 4) * 85));
        send_word(KIND_PUSH, 8'hAA, 8'h55);
        for (int i = 0; i < 3; i++)
            send_word(KIND_POP, ID_BITS'($urandom_range(0, 255)),
                      PRIO_BITS'($urandom_range(0, 255)));

        burst_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (burst_left == 0) begin
                // bias each burst toward filling, draining or churning
                burst_left = $urandom_range(15, 60);
                case ($urandom_range(0, 4))
                    0: push_pct = 10;
                    1: push_pct = 30;
                    2: push_pct = 50;
                    3: push_pct = 70;
                    default: push_pct = 90;
                endcase
                idle_mode = $urandom_range(0, 2);
            end
            burst_left--;
            if ($urandom_range(0, 99) < push_pct)
                send_word(KIND_PUSH, ID_BITS'($urandom_range(0, 255)), pick_priority());
            else
                send_word(KIND_POP, ID_BITS'($urandom_range(0, 255)),
                          PRIO_BITS'($urandom_range(0, 255)));
        end
        s_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("[stable_priority_ready_queue] OK");
        else
            $display("[stable_priority_ready_queue] ERROR");
        $finish;
    end

endmodule
